// ===== rtl/isri_pkg.sv =====
package isri_pkg;
  localparam int unsigned DepthDefault = 64;
  localparam int unsigned StampW = 32;
  localparam int unsigned ValW = 16;
  localparam int unsigned NumVal = 6;
  localparam int unsigned EntryW = StampW + NumVal * ValW;
  localparam int unsigned FillW = 7;

  typedef enum logic [1:0] {
    CmdPush   = 2'd0,
    CmdPrune  = 2'd1,
    CmdInterp = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;
endpackage

// ===== rtl/isri_ram.sv =====
module isri_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/imu_sample_ring_interpolator_core.sv =====
// Push writes the sample on accept; prune reads and drops the oldest samples one by
// one; interpolate runs a stamp scan, then one 49-step serial divide per value.
// Throughput: one item at a time; busy_o is high from accept to result strobe.
// The result strobe done_o lasts one cycle; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) empties the ring; store contents are not
// cleared and entries are only read once written.
module imu_sample_ring_interpolator_core #(
  parameter int unsigned Depth = isri_pkg::DepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    cmd_i,
  input  logic [isri_pkg::StampW-1:0]   stamp_i,
  input  logic signed [15:0]            acc_x_i,
  input  logic signed [15:0]            acc_y_i,
  input  logic signed [15:0]            acc_z_i,
  input  logic signed [15:0]            rate_x_i,
  input  logic signed [15:0]            rate_y_i,
  input  logic signed [15:0]            rate_z_i,
  output logic                          done_o,
  output logic                          found_o,
  output logic [isri_pkg::StampW-1:0]   out_stamp_o,
  output logic signed [15:0]            out_acc_x_o,
  output logic signed [15:0]            out_acc_y_o,
  output logic signed [15:0]            out_acc_z_o,
  output logic signed [15:0]            out_rate_x_o,
  output logic signed [15:0]            out_rate_y_o,
  output logic signed [15:0]            out_rate_z_o,
  output logic [isri_pkg::FillW-1:0]    fill_count_o
);
  import isri_pkg::*;

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam int unsigned QW = 49;  // |d*off| < 2^49

  typedef enum logic [3:0] {
    StIdle, StPruneRd, StPruneChk, StScanRd, StScanChk,
    StLoadA, StLoadB, StDelta, StMul, StDiv, StDone
  } state_e;

  state_e                state_q;
  logic [StampW-1:0]     t_q;
  logic [AW-1:0]         oldest_q;
  logic [CW-1:0]         held_q;
  logic [CW-1:0]         k_q;       // scan position
  logic [StampW-1:0]     prev_stamp_q;
  logic                  first_q;
  logic [CW-1:0]         sel_q;     // chosen lower index
  logic                  hit_q;
  logic [EntryW-1:0]     a_q;
  logic [StampW:0]       dt_q;      // |b.stamp - a.stamp|
  logic                  dneg_q;    // b.stamp < a.stamp
  logic signed [StampW:0] off_q;    // t - a.stamp, may be negative
  logic [2:0]            lane_q;
  logic [5:0]            bit_q;
  logic                  neg_q;
  logic [QW-1:0]         num_q;
  logic [StampW:0]       rem_q;
  logic [QW-1:0]         quo_q;
  logic signed [ValW-1:0] res_q [NumVal];
  logic                  found_q;
  logic                  done_q;

  // memory
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [EntryW-1:0] wdata, rdata;

  isri_ram #(.Width(EntryW), .Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] pos);
    logic [CW:0] s;
    s = {{(CW-AW+1){1'b0}}, base} + {1'b0, pos};
    if (s >= (CW+1)'(Depth)) s = s - (CW+1)'(Depth);
    return s[AW-1:0];
  endfunction

  wire accept = start_i && (state_q == StIdle);
  wire full = (held_q == CW'(Depth));

  // Read address: the oldest entry while pruning, entry k while scanning,
  // lower pair entry in StLoadA, upper pair entry from StLoadB on. The upper
  // entry stays on rdata through StDelta, StMul and StDiv.
  always_comb begin
    we = accept && (cmd_e'(cmd_i) == CmdPush);
    waddr = full ? oldest_q : slot(oldest_q, held_q);
    wdata = {stamp_i, acc_x_i, acc_y_i, acc_z_i, rate_x_i, rate_y_i, rate_z_i};
    case (state_q)
      StPruneRd, StPruneChk: raddr = oldest_q;
      StScanRd, StScanChk:   raddr = slot(oldest_q, k_q);
      StLoadA:               raddr = slot(oldest_q, sel_q);
      default:               raddr = slot(oldest_q, sel_q + CW'(1));
    endcase
  end

  wire [StampW-1:0] rd_stamp = rdata[EntryW-1 -: StampW];
  function automatic logic signed [ValW-1:0] lane_val(input logic [EntryW-1:0] e,
                                                      input logic [2:0] l);
    return e[(NumVal-1-l)*ValW +: ValW];
  endfunction

  // signed stamp differences against the lower pair entry
  logic signed [StampW:0] dt_s, off_s;
  always_comb begin
    dt_s  = $signed({1'b0, rd_stamp}) - $signed({1'b0, a_q[EntryW-1 -: StampW]});
    off_s = $signed({1'b0, t_q}) - $signed({1'b0, a_q[EntryW-1 -: StampW]});
  end

  // product d*off, registered, then serial restoring divide of |p| by |dt|
  logic signed [ValW-1:0] a_lane, b_lane;
  logic signed [ValW:0]   dv;
  logic signed [QW:0]     prod;
  always_comb begin
    a_lane = lane_val(a_q, lane_q);
    b_lane = lane_val(rdata, lane_q);
    dv = $signed({b_lane[ValW-1], b_lane}) - $signed({a_lane[ValW-1], a_lane});
    prod = dv * off_q;
  end

  logic [StampW+1:0] trial;
  logic signed [QW+1:0] sum;
  logic signed [ValW-1:0] satv;
  always_comb begin
    trial = {rem_q, num_q[QW-1]} - {1'b0, dt_q};
    sum = $signed({{(QW+2-ValW){a_lane[ValW-1]}}, a_lane})
        + (neg_q ? -$signed({2'b0, quo_q}) : $signed({2'b0, quo_q}));
    if (sum > 32767) satv = 16'sh7fff;
    else if (sum < -32768) satv = 16'sh8000;
    else satv = sum[ValW-1:0];
  end

  wire [QW-1:0] quo_n = {quo_q[QW-2:0], ~trial[StampW+1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      oldest_q <= '0;
      held_q <= '0;
      done_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept) begin
            t_q <= stamp_i;
            found_q <= 1'b0;
            case (cmd_e'(cmd_i))
              CmdPush: begin
                if (full) oldest_q <= slot(oldest_q, CW'(1));
                else held_q <= held_q + CW'(1);
                state_q <= StDone;
              end
              CmdPrune: state_q <= StPruneRd;
              CmdInterp: begin
                if (held_q < CW'(2)) state_q <= StDone;
                else begin
                  k_q <= '0; first_q <= 1'b1; hit_q <= 1'b0;
                  sel_q <= held_q - CW'(2);
                  state_q <= StScanRd;
                end
              end
              default: state_q <= StDone;
            endcase
          end
        end
        StPruneRd: state_q <= (held_q == '0) ? StDone : StPruneChk;
        StPruneChk: begin
          if (rd_stamp < t_q) begin
            oldest_q <= slot(oldest_q, CW'(1));
            held_q <= held_q - CW'(1);
            state_q <= StPruneRd;
          end else state_q <= StDone;
        end
        StScanRd: state_q <= StScanChk;
        StScanChk: begin
          prev_stamp_q <= rd_stamp;
          first_q <= 1'b0;
          if (first_q && t_q < rd_stamp) state_q <= StDone;
          else begin
            if (!first_q && !hit_q && prev_stamp_q <= t_q && t_q < rd_stamp) begin
              hit_q <= 1'b1; sel_q <= k_q - CW'(1);
            end
            if (k_q == held_q - CW'(1)) begin
              if (t_q > rd_stamp) state_q <= StDone;
              else if (t_q == rd_stamp) begin
                found_q <= 1'b1;
                for (int i = 0; i < NumVal; i++) res_q[i] <= lane_val(rdata, 3'(i));
                state_q <= StDone;
              end else state_q <= StLoadA;
            end else begin
              k_q <= k_q + CW'(1);
              state_q <= StScanRd;
            end
          end
        end
        StLoadA: state_q <= StLoadB;
        StLoadB: begin
          a_q <= rdata;  // lower pair entry
          state_q <= StDelta;
        end
        StDelta: begin
          // rdata holds the upper pair entry from here on
          dt_q <= dt_s[StampW] ? -dt_s : dt_s;
          dneg_q <= dt_s[StampW];
          off_q <= off_s;
          lane_q <= '0;
          found_q <= 1'b1;
          state_q <= StMul;
        end
        StMul: begin
          if (dt_q == '0) begin
            for (int i = 0; i < NumVal; i++) res_q[i] <= lane_val(a_q, 3'(i));
            state_q <= StDone;
          end else begin
            neg_q <= prod[QW] ^ dneg_q;
            num_q <= prod[QW] ? QW'(-prod) : prod[QW-1:0];
            rem_q <= '0; quo_q <= '0; bit_q <= '0;
            state_q <= StDiv;
          end
        end
        StDiv: begin
          if (bit_q == 6'(QW)) begin
            res_q[lane_q] <= satv;
            if (lane_q == 3'(NumVal-1)) state_q <= StDone;
            else begin lane_q <= lane_q + 3'd1; state_q <= StMul; end
          end else begin
            rem_q <= trial[StampW+1] ? {rem_q[StampW-1:0], num_q[QW-1]} : trial[StampW:0];
            num_q <= {num_q[QW-2:0], 1'b0};
            quo_q <= quo_n;
            bit_q <= bit_q + 6'd1;
          end
        end
        StDone: begin
          done_q <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = done_q;
  assign found_o = done_q & found_q;
  assign out_stamp_o = found_o ? t_q : '0;
  assign out_acc_x_o = found_o ? res_q[0] : '0;
  assign out_acc_y_o = found_o ? res_q[1] : '0;
  assign out_acc_z_o = found_o ? res_q[2] : '0;
  assign out_rate_x_o = found_o ? res_q[3] : '0;
  assign out_rate_y_o = found_o ? res_q[4] : '0;
  assign out_rate_z_o = found_o ? res_q[5] : '0;
  assign fill_count_o = done_q ? FillW'(held_q) : '0;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_o)
    else $error("strobe while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) held_q <= CW'(Depth))
    else $error("fill overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) found_o |-> done_o)
    else $error("found without strobe");
endmodule
